FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers used by the scanner design; all sample on posedge clk and
// are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// expression never true
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);
`else
`define ASSERT_IMPLY(lbl, ante, cons, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

FILE: design/slms_pkg.sv
// ----------------------------------------------------------------------------
// slms_pkg
// Types and constants of the led matrix column scanner.
// ----------------------------------------------------------------------------
package slms_pkg;

  localparam int COLUMNS    = 8;
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROWS       = 8;
  localparam int ROW_W      = 8;
  localparam int MAX_CHARS  = 32;
  localparam int CHAR_W     = 6;
  localparam int ADDR_W     = 8;
  localparam int STORE_DEPTH = 1 << ADDR_W;
  localparam int STEP_W     = 9;            // up to (MAX_CHARS+1)*COLUMNS steps
  localparam int VPOS_W     = STEP_W + 1;
  localparam int REPS_W     = 12;           // 65535/25 fits
  localparam int TIME_W     = 16;
  localparam int CFG_IDX_W  = 2;

  // x/25 as (x*RECIP_25) >> RECIP_SHIFT, exact for 16-bit x
  localparam int RECIP_W     = 17;
  localparam int RECIP_SHIFT = 21;
  localparam logic [RECIP_W-1:0] RECIP_25 = 17'd83887;
  localparam int PROD_W      = TIME_W + RECIP_W;

  localparam logic [ROW_W-1:0] ROW_MASK = ROW_W'((1 << ROWS) - 1);

  // operations
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // display modes
  localparam logic [1:0] MODE_SHOW      = 2'd0;
  localparam logic [1:0] MODE_ROTATE    = 2'd1;
  localparam logic [1:0] MODE_SCROLL_RL = 2'd2;
  localparam logic [1:0] MODE_SCROLL_LR = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARS = 2'd3;

  localparam logic [REPS_W-1:0] SHOW_REPS_RST = 12'd40;  // 1000 ms
  localparam logic [REPS_W-1:0] MOVE_REPS_RST = 12'd4;   // 100 ms
  localparam logic [CHAR_W-1:0] CHARS_RST     = 6'd1;

  typedef struct packed {
    logic [1:0]        operation;
    logic [ADDR_W-1:0] column_address;
    logic [ROW_W-1:0]  column_bits;
  } in_word_t;

  typedef struct packed {
    logic [ROW_W-1:0] row_bits;
    logic [COL_W-1:0] column_select;
    logic             column_enable;
    logic             sequence_last;
  } out_word_t;

endpackage

FILE: design/slms_ram.sv
// ----------------------------------------------------------------------------
// slms_ram
// Single write port, single read port ram with registered read data.
// ----------------------------------------------------------------------------
module slms_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/scrolling_led_matrix_scanner.sv
// ----------------------------------------------------------------------------
// scrolling_led_matrix_scanner
// Column scan sequencer for an 8x8 led matrix with show, rotate and scroll.
// ----------------------------------------------------------------------------
// Usage:
//   A word on in_word is taken at a clock edge where start is high and busy
//   is low. Load words write one column byte into the column store, start
//   words latch the registers and restart the sequence, tick words drive one
//   column slot. Every tick gives one result in the cycle after it is taken,
//   shown for a single cycle with out_strobe high; loads and starts give none.
//   Registers are written over cfg_valid/cfg_ready (ready always high); the user
//   must write them only while the block is idle, which the block does not
//   enforce. The time registers are turned into scan counts as they are written.
//   Throughput is one word per cycle: the single read port of the column
//   store is read at the accept edge and its registered output feeds
//   row_bits. busy therefore stays low.
//   Reset clears the sequencer (not running, counters zero) and loads the
//   register defaults; the column store is not cleared, and the user must read
//   entries only after they were written, which the block does not enforce. The receiver cannot hold off results.
// ----------------------------------------------------------------------------
module scrolling_led_matrix_scanner (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  slms_pkg::in_word_t                  in_word,
  output logic                                out_strobe,
  output slms_pkg::out_word_t                 out_word,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [slms_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [slms_pkg::TIME_W-1:0]         cfg_data
);
  import slms_pkg::*;

  // configuration
  logic [1:0]        mode_r;
  logic [REPS_W-1:0] show_reps_r, move_reps_r;
  logic [CHAR_W-1:0] chars_r;
  logic [PROD_W-1:0] recip_prod;
  logic [REPS_W-1:0] cfg_reps;
  logic              cfg_we;

  // latched sequence setup
  logic [1:0]        lat_mode_r;
  logic [REPS_W-1:0] lat_reps_r;
  logic [STEP_W-1:0] lat_steps_r;

  // sequencer state
  logic              running_r, running_nxt;
  logic [STEP_W-1:0] shift_r, shift_nxt;
  logic [REPS_W-1:0] scan_r, scan_nxt;
  logic [COL_W-1:0]  col_cnt_r, col_cnt_nxt;

  // result pipeline
  logic              out_strobe_r;
  logic              out_blank_r, out_blank_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  logic              out_en_r;
  logic              out_last_r, out_last_nxt;

  logic              accept, do_load, do_start, do_tick;
  logic [CHAR_W-1:0] sat_chars;
  logic [REPS_W-1:0] start_reps;
  logic [STEP_W-1:0] start_steps;
  logic [VPOS_W-1:0] vpos;
  logic [VPOS_W-1:0] ppos;
  logic [ADDR_W-1:0] rd_addr;
  logic [ROW_W-1:0]  rd_data;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign do_load   = accept && (in_word.operation == OP_LOAD);
  assign do_start  = accept && (in_word.operation == OP_START);
  assign do_tick   = accept && (in_word.operation == OP_TICK);
  assign cfg_we    = cfg_valid && cfg_ready;

  // divide by 25 through the reciprocal
  assign recip_prod = PROD_W'(cfg_data) * PROD_W'(RECIP_25);
  assign cfg_reps   = recip_prod[RECIP_SHIFT +: REPS_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_SHOW;
      show_reps_r <= SHOW_REPS_RST;
      move_reps_r <= MOVE_REPS_RST;
      chars_r     <= CHARS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:  mode_r      <= cfg_data[1:0];
        CFG_SHOW:  show_reps_r <= cfg_reps;
        CFG_MOVE:  move_reps_r <= cfg_reps;
        CFG_CHARS: chars_r     <= cfg_data[CHAR_W-1:0];
        default:   mode_r      <= mode_r;
      endcase
    end
  end

  // start setup
  always_comb begin
    sat_chars = (chars_r > CHAR_W'(MAX_CHARS)) ? CHAR_W'(MAX_CHARS) : chars_r;
    unique case (mode_r)
      MODE_SHOW: begin
        start_reps  = show_reps_r;
        start_steps = STEP_W'(1);
      end
      MODE_ROTATE: begin
        start_reps  = move_reps_r;
        start_steps = STEP_W'(COLUMNS);
      end
      default: begin
        start_reps  = move_reps_r;
        start_steps = STEP_W'((STEP_W'(sat_chars) + STEP_W'(1)) * STEP_W'(COLUMNS));
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_start) begin
      lat_mode_r  <= mode_r;
      lat_reps_r  <= start_reps;
      lat_steps_r <= start_steps;
    end
  end

  // store address and slot fields for a tick
  always_comb begin
    vpos          = VPOS_W'(shift_r) + VPOS_W'(col_cnt_r);
    ppos          = vpos - VPOS_W'(COLUMNS);
    rd_addr       = ADDR_W'(col_cnt_r);
    out_col_nxt   = col_cnt_r;
    out_blank_nxt = !running_r;
    unique case (lat_mode_r)
      MODE_SHOW: begin
        rd_addr = ADDR_W'(col_cnt_r);
      end
      MODE_ROTATE: begin
        rd_addr = ADDR_W'(COL_W'(col_cnt_r + shift_r[COL_W-1:0]));
      end
      MODE_SCROLL_RL: begin
        rd_addr = ppos[ADDR_W-1:0];
        // before the strip or past its end
        if (vpos < VPOS_W'(COLUMNS) || vpos >= VPOS_W'(lat_steps_r)) begin
          out_blank_nxt = 1'b1;
        end
      end
      MODE_SCROLL_LR: begin
        rd_addr     = {ppos[ADDR_W-1:COL_W], ~ppos[COL_W-1:0]};
        out_col_nxt = ~col_cnt_r;
        if (vpos < VPOS_W'(COLUMNS) || vpos >= VPOS_W'(lat_steps_r)) begin
          out_blank_nxt = 1'b1;
        end
      end
      default: begin
        rd_addr = ADDR_W'(col_cnt_r);
      end
    endcase
    if (!running_r) begin
      out_col_nxt = '0;
    end
  end

  // counter update
  always_comb begin
    running_nxt  = running_r;
    shift_nxt    = shift_r;
    scan_nxt     = scan_r;
    col_cnt_nxt  = col_cnt_r;
    out_last_nxt = 1'b0;
    if (do_start) begin
      running_nxt = (start_reps != '0);
      shift_nxt   = '0;
      scan_nxt    = '0;
      col_cnt_nxt = '0;
    end else if (do_tick && running_r) begin
      col_cnt_nxt = col_cnt_r + COL_W'(1);
      if (col_cnt_r == COL_W'(COLUMNS - 1)) begin
        if ((REPS_W + 1)'(scan_r) + (REPS_W + 1)'(1) >= (REPS_W + 1)'(lat_reps_r)) begin
          scan_nxt = '0;
          if ((STEP_W + 1)'(shift_r) + (STEP_W + 1)'(1) >= (STEP_W + 1)'(lat_steps_r)) begin
            shift_nxt    = '0;
            running_nxt  = 1'b0;
            out_last_nxt = 1'b1;
          end else begin
            shift_nxt = shift_r + STEP_W'(1);
          end
        end else begin
          scan_nxt = scan_r + REPS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r    <= 1'b0;
      shift_r      <= '0;
      scan_r       <= '0;
      col_cnt_r    <= '0;
      out_strobe_r <= 1'b0;
      out_last_r   <= 1'b0;
      out_en_r     <= 1'b0;
    end else begin
      running_r    <= running_nxt;
      shift_r      <= shift_nxt;
      scan_r       <= scan_nxt;
      col_cnt_r    <= col_cnt_nxt;
      out_strobe_r <= do_tick;
      out_last_r   <= out_last_nxt;
      out_en_r     <= do_tick && running_r;
    end
  end

  always_ff @(posedge clk) begin
    if (do_tick) begin
      out_blank_r <= out_blank_nxt;
      out_col_r   <= out_col_nxt;
    end
  end

  slms_ram #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (ROW_W)
  ) u_store (
    .clk   (clk),
    .we    (do_load),
    .waddr (in_word.column_address),
    .wdata (in_word.column_bits),
    .re    (do_tick),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign out_strobe             = out_strobe_r;
  assign out_word.row_bits      = out_blank_r ? '0 : (rd_data & ROW_MASK);
  assign out_word.column_select = out_col_r;
  assign out_word.column_enable = out_en_r;
  assign out_word.sequence_last = out_last_r;

`include "assert_macros.svh"

  `ASSERT_IMPLY(a_last_enabled, out_strobe && out_word.sequence_last, out_word.column_enable, "last slot without enable")
  `ASSERT_IMPLY(a_last_stops, out_strobe && out_word.sequence_last, !running_r, "still running after last slot")
  `ASSERT_IMPLY(a_shift_bound, running_r, shift_r < lat_steps_r, "step index past sequence")
  `ASSERT_IMPLY(a_off_dark, out_strobe && !out_word.column_enable, out_word.row_bits == '0 && !out_word.sequence_last, "dark slot with rows lit")
  `ASSERT_NEVER(a_busy_low, busy, "busy raised")

endmodule

FILE: test/scrolling_led_matrix_scanner_tb.sv
// ----------------------------------------------------------------------------
// scrolling_led_matrix_scanner_tb
// Self-checking bench for the led matrix column scan sequencer. It fills the
// column store, then plays show, rotate and both scroll directions under
// directed and random settings, with random sender gaps. Every column slot
// is compared field by field against a cycle-free model kept in the bench.
// ----------------------------------------------------------------------------
module scrolling_led_matrix_scanner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import slms_pkg::*;

  localparam int unsigned SCAN_MS          = 25;
  localparam int unsigned CYCLE_LIMIT      = 400_000;
  localparam int unsigned LONG_STRIP_TICKS = 64;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 start     = 1'b0;
  logic                 busy;
  in_word_t             in_word   = '0;
  logic                 out_strobe;
  out_word_t            out_word;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MODE;
  logic [TIME_W-1:0]    cfg_data  = '0;

  scrolling_led_matrix_scanner uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_strobe(out_strobe),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // register copies, reset defaults
  logic [1:0]        mode_reg    = MODE_SHOW;
  logic [TIME_W-1:0] show_ms_reg = 16'd1000;
  logic [TIME_W-1:0] move_ms_reg = 16'd100;
  logic [CHAR_W-1:0] chars_reg   = CHARS_RST;

  // sequencer state of the scan model
  logic [ROW_W-1:0]  column_bytes [STORE_DEPTH];
  logic              seq_active  = 1'b0;
  logic [1:0]        seq_mode    = MODE_SHOW;
  int unsigned       seq_scans   = 0;
  int unsigned       seq_steps   = 0;
  int unsigned       seq_chars   = 0;
  int unsigned       step_pos    = 0;
  int unsigned       scan_pos    = 0;
  int unsigned       slot_pos    = 0;

  out_word_t         expected_slots [$];

  int                errors        = 0;
  int                words_sent    = 0;
  int                slots_checked = 0;
  int                done_by_mode [4] = '{0, 0, 0, 0};
  int                idle_pct      = 0;
  int unsigned       cycles        = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d slots outstanding", cycles,
               expected_slots.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic report(string what, int got, int want);
    errors++;
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
  endtask

  // model of one accepted word; a tick queues the slot it must produce
  task automatic scan_model(in_word_t w);
    out_word_t   slot;
    int unsigned rows, col, vpos, dcol;
    slot = '0;
    rows = 0;
    col  = 0;
    case (w.operation)
      OP_LOAD: column_bytes[w.column_address] = w.column_bits;
      OP_START: begin
        seq_mode  = mode_reg;
        seq_chars = (chars_reg > MAX_CHARS) ? MAX_CHARS : chars_reg;
        if (seq_mode == MODE_SHOW) begin
          seq_scans = show_ms_reg / SCAN_MS;
          seq_steps = 1;
        end else begin
          seq_scans = move_ms_reg / SCAN_MS;
          seq_steps = (seq_mode == MODE_ROTATE) ? COLUMNS : (seq_chars + 1) * COLUMNS;
        end
        step_pos   = 0;
        scan_pos   = 0;
        slot_pos   = 0;
        seq_active = (seq_scans != 0);
      end
      OP_TICK: begin
        if (seq_active) begin
          slot.column_enable = 1'b1;
          if (seq_mode == MODE_SHOW) begin
            rows = column_bytes[slot_pos];
            col  = slot_pos;
          end else if (seq_mode == MODE_ROTATE) begin
            rows = column_bytes[(slot_pos + step_pos) % COLUMNS];
            col  = slot_pos;
          end else begin
            // step index runs one character ahead of the strip
            vpos = step_pos + slot_pos;
            col  = (seq_mode == MODE_SCROLL_RL) ? slot_pos : COLUMNS - 1 - slot_pos;
            if (vpos < COLUMNS || vpos - COLUMNS >= seq_chars * COLUMNS) begin
              rows = 0;
            end else begin
              vpos = vpos - COLUMNS;
              dcol = vpos % COLUMNS;
              if (seq_mode == MODE_SCROLL_LR)
                dcol = COLUMNS - 1 - dcol;
              rows = column_bytes[ADDR_W'((vpos / COLUMNS) * COLUMNS + dcol)];
            end
          end
          slot_pos++;
          if (slot_pos >= COLUMNS) begin
            slot_pos = 0;
            scan_pos++;
            if (scan_pos >= seq_scans) begin
              scan_pos = 0;
              step_pos++;
              if (step_pos >= seq_steps) begin
                step_pos           = 0;
                seq_active         = 1'b0;
                slot.sequence_last = 1'b1;
                done_by_mode[seq_mode]++;
              end
            end
          end
        end
        slot.row_bits      = ROW_W'(rows) & ROW_MASK;
        slot.column_select = COL_W'(col);
        expected_slots.push_back(slot);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : check_slots
    out_word_t want;
    if (rst_n && out_strobe) begin
      if (expected_slots.size() == 0) begin
        report("unexpected slot", out_word, 0);
      end else begin
        want = expected_slots.pop_front();
        if (out_word.row_bits !== want.row_bits)
          report("row_bits", out_word.row_bits, want.row_bits);
        if (out_word.column_select !== want.column_select)
          report("column_select", out_word.column_select, want.column_select);
        if (out_word.column_enable !== want.column_enable)
          report("column_enable", out_word.column_enable, want.column_enable);
        if (out_word.sequence_last !== want.sequence_last)
          report("sequence_last", out_word.sequence_last, want.sequence_last);
        slots_checked++;
      end
    end
  end

  task automatic send_word(logic [1:0] op, logic [ADDR_W-1:0] addr, logic [ROW_W-1:0] bits);
    in_word_t w;
    w.operation      = op;
    w.column_address = addr;
    w.column_bits    = bits;
    // each cycle idles with the set percentage
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    words_sent++;
    scan_model(w);
  endtask

  task automatic tick();
    send_word(OP_TICK, ADDR_W'($urandom), ROW_W'($urandom));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (expected_slots.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic cfg_put(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MODE:  mode_reg    = data[1:0];
      CFG_SHOW:  show_ms_reg = data;
      CFG_MOVE:  move_ms_reg = data;
      CFG_CHARS: chars_reg   = data[CHAR_W-1:0];
      default: ;
    endcase
  endtask

  // only called with no slot outstanding
  task automatic write_settings(logic [1:0] mode, logic [TIME_W-1:0] show_ms,
                                logic [TIME_W-1:0] move_ms, logic [CHAR_W-1:0] chars);
    cfg_put(CFG_MODE, TIME_W'(mode));
    cfg_put(CFG_SHOW, show_ms);
    cfg_put(CFG_MOVE, move_ms);
    cfg_put(CFG_CHARS, TIME_W'(chars));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [TIME_W-1:0] pick_time();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 5)
      return TIME_W'($urandom_range(0, SCAN_MS - 1));
    if (pick < 85)
      return TIME_W'(SCAN_MS * $urandom_range(1, 3) + $urandom_range(0, SCAN_MS - 1));
    return TIME_W'($urandom_range(0, 65535));
  endfunction

  task automatic test_column_store_fill();
    idle_pct = 11;
    for (int a = 0; a < STORE_DEPTH; a++)
      send_word(OP_LOAD, ADDR_W'(a),
                (a == 0) ? 8'hFF : (a == 1) ? 8'h00 : ROW_W'($urandom));
  endtask

  task automatic test_directed_cases();
    idle_pct = 0;
    // ticks with nothing running, and the unused operation
    tick();
    send_word(OP_NONE, 8'hFF, 8'hFF);
    tick();
    // reset defaults: show mode, 40 scans
    send_word(OP_START, 8'h00, 8'h00);
    repeat (3) tick();
    // empty sequences in show and scroll
    wait_drained();
    write_settings(MODE_SHOW, 16'd24, 16'd0, 6'd1);
    send_word(OP_START, 8'hAA, 8'h55);
    tick();
    wait_drained();
    write_settings(MODE_SCROLL_RL, 16'hFFFF, 16'd0, 6'd0);
    send_word(OP_START, 8'h55, 8'hAA);
    tick();
    // longest step, then a restart while running
    wait_drained();
    write_settings(MODE_ROTATE, 16'd0, 16'hFFFF, 6'd63);
    send_word(OP_START, 8'h00, 8'h00);
    repeat (3) tick();
    send_word(OP_START, 8'h00, 8'h00);
    repeat (2) tick();
    // zero characters: blank strip with mirrored columns
    wait_drained();
    write_settings(MODE_SCROLL_LR, 16'd25, 16'd25, 6'd0);
    send_word(OP_START, 8'h00, 8'h00);
    repeat (2) tick();
  endtask

  task automatic play_random_sequence();
    int unsigned total, budget, pick, n;
    wait_drained();
    if ($urandom_range(99) < 70)
      write_settings(2'($urandom_range(0, 3)), pick_time(), pick_time(),
                     CHAR_W'(($urandom_range(99) < 85) ? $urandom_range(0, 2)
                                                       : $urandom_range(3, 63)));
    send_word(OP_START, ADDR_W'($urandom), ROW_W'($urandom));
    total  = seq_scans * seq_steps * COLUMNS;
    budget = (total <= 600) ? total : $urandom_range(50, 300);
    if ($urandom_range(99) < 15)
      budget = $urandom_range(0, budget);
    n = 0;
    while (n < budget) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_word(OP_LOAD, ADDR_W'($urandom), ROW_W'($urandom));
      end else if (pick < 10) begin
        send_word(OP_NONE, ADDR_W'($urandom), ROW_W'($urandom));
      end else if (pick < 11) begin
        send_word(OP_START, ADDR_W'($urandom), ROW_W'($urandom));
      end else if (pick < 12) begin
        // hold off until every slot so far is out
        wait_drained();
      end else begin
        tick();
        n++;
      end
    end
    repeat ($urandom_range(0, 2)) tick();
  endtask

  task automatic test_random_play(int pct, int n_words);
    int stop_at;
    idle_pct = pct;
    stop_at  = words_sent + n_words;
    while (words_sent < stop_at)
      play_random_sequence();
  endtask

  // strip of MAX_CHARS characters or more requested, first scans of it
  task automatic test_long_strip();
    idle_pct = 11;
    wait_drained();
    write_settings($urandom_range(1) ? MODE_SCROLL_LR : MODE_SCROLL_RL, pick_time(),
                   TIME_W'(SCAN_MS + $urandom_range(0, SCAN_MS - 1)),
                   CHAR_W'($urandom_range(MAX_CHARS, 63)));
    send_word(OP_START, ADDR_W'($urandom), ROW_W'($urandom));
    repeat (LONG_STRIP_TICKS) tick();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_column_store_fill();
    test_directed_cases();
    test_random_play(11, 150);
    test_random_play(46, 150);
    test_random_play(0, 150);
    test_long_strip();

    wait_drained();
    repeat (4) @(posedge clk);
    while (expected_slots.size() != 0)
      report("missing slot", 0, expected_slots.pop_front());

    $display("sent %0d words, checked %0d column slots, %0d mismatches", words_sent,
             slots_checked, errors);
    $display("sequences played out: show %0d, rotate %0d, scroll r-l %0d, scroll l-r %0d",
             done_by_mode[MODE_SHOW], done_by_mode[MODE_ROTATE],
             done_by_mode[MODE_SCROLL_RL], done_by_mode[MODE_SCROLL_LR]);
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
